// ===== rtl/bsxc_pkg.sv =====
`timescale 1ns / 1ps

package bsxc_pkg;

  // Block memory geometry
  localparam int MemDepth = 4096;
  localparam int MemAddrW = $clog2(MemDepth);
  localparam int SizeW    = 13;
  localparam logic [SizeW-1:0] BlockMax = SizeW'(MemDepth);

  // One port request into the block memory
  typedef struct packed {
    logic                we;
    logic [MemAddrW-1:0] waddr;
    logic [7:0]          wdata;
    logic [MemAddrW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/bsxc_mem.sv =====
`timescale 1ns / 1ps

module bsxc_mem import bsxc_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [MemDepth];
  logic [7:0] rdata_q;

  // Write port and registered read port, read returns the old value on a collision
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/block_send_xor_checksum_retry_top.sv =====
`timescale 1ns / 1ps

// Stop-and-wait block sender with XOR checksum and retries.
// Input stream (s_axis): tuser carries the opcode (load, start, exchange done,
// exchange timed out), tdata carries the memory address and the data byte.
// A load writes one byte into the 4096-byte block memory and gives no result.
// A start, and every exchange while a transfer runs, gives one result item on
// m_axis: the next byte to send, or an end item (tlast high) with the status.
// An exchange or timeout while no transfer runs is dropped without a result.
// Each item runs through accept and execute (the registered block memory read
// issued at accept is back, the phase logic decides); an item with a result
// then presents it from the single result register. A new item is taken
// only once the last one has left execute and, if it has one, the result
// register. While the result register holds an item the input is not ready,
// so a stall on m_axis simply holds the block; nothing is lost.
// Reset clears the transfer phase, counters and the result register and loads
// the register defaults (block_size 256, retry_limit 3); the block memory is
// not cleared and must be loaded before it is sent.
// Registers on APB: block_size at 0x0, retry_limit at 0x4.

module block_send_xor_checksum_retry_top import bsxc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // address[11:0], data[19:12], zero[23:20]
  input  logic [1:0]  s_axis_tuser_i,   // opcode[1:0]
  // result item stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // send_byte[7:0], send_valid[8], status[11:9],
                                        // zero[15:12]
  output logic        m_axis_tlast_o,   // finished
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [7:0] StartCode = 8'hA0;

  typedef enum logic [1:0] {
    OpLoad    = 2'd0,
    OpStart   = 2'd1,
    OpExch    = 2'd2,
    OpTimeout = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StRun     = 3'd0,
    StOk      = 3'd1,
    StConn    = 3'd2,
    StCrc     = 3'd3,
    StTimeout = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhSync   = 3'd1,
    PhRetry  = 3'd2,
    PhSizeLo = 3'd3,
    PhSizeHi = 3'd4,
    PhData   = 3'd5,
    PhCheck  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CtrlIn,
    CtrlExec,
    CtrlOut
  } ctrl_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SizeW-1:0] cfg_size_q;
  logic [7:0]       cfg_retry_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {24'b0, cfg_retry_q} : {{(32-SizeW){1'b0}}, cfg_size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q  <= SizeW'(256);
      cfg_retry_q <= 8'd3;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        cfg_retry_q <= pwdata[7:0];
      end else begin
        cfg_size_q <= pwdata[SizeW-1:0];
      end
    end
  end

  // Size clamped to the memory depth, used for both the size bytes and the data
  logic [SizeW-1:0] eff_size;
  assign eff_size = (cfg_size_q > BlockMax) ? BlockMax : cfg_size_q;

  // ---------------------------------------------------------------------------
  // Control and transfer state
  // ---------------------------------------------------------------------------
  ctrl_e            ctrl_q, ctrl_d;
  phase_e           phase_q, phase_d;
  logic [SizeW-1:0] idx_q, idx_d;
  logic [7:0]       cks_q, cks_d;
  logic [7:0]       retries_q, retries_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_sv_q, out_sv_d;
  logic [2:0]       out_status_q, out_status_d;
  logic             out_fin_q, out_fin_d;

  // Accepted item, held for the execute step
  op_e                 op_q;
  logic [MemAddrW-1:0] addr_q;
  logic [7:0]          data_q;

  logic     in_acc;
  mem_req_t mem_req;
  logic [7:0] mem_rdata;

  assign s_axis_tready_o = (ctrl_q == CtrlIn);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(s_axis_tuser_i);
      addr_q <= s_axis_tdata_i[MemAddrW-1:0];
      data_q <= s_axis_tdata_i[19:12];
    end
  end

  // Read address: a new pass starts at entry zero, a data step reads the index
  always_comb begin
    mem_req.raddr = ((phase_q == PhSizeHi) || (phase_q == PhCheck)) ? '0
                                                                     : idx_q[MemAddrW-1:0];
    mem_req.we    = (ctrl_q == CtrlExec) && (op_q == OpLoad);
    mem_req.waddr = addr_q;
    mem_req.wdata = data_q;
  end

  bsxc_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Execute step: phase update and result
  // ---------------------------------------------------------------------------
  logic             do_pass, do_next;
  logic [7:0]       pass_retries;
  logic [SizeW-1:0] idx_use;
  logic [7:0]       cks_use;

  always_comb begin
    ctrl_d       = ctrl_q;
    phase_d      = phase_q;
    idx_d        = idx_q;
    cks_d        = cks_q;
    retries_d    = retries_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_sv_d     = out_sv_q;
    out_status_d = out_status_q;
    out_fin_d    = out_fin_q;
    do_pass      = 1'b0;
    do_next      = 1'b0;
    pass_retries = retries_q;
    idx_use      = idx_q;
    cks_use      = cks_q;

    unique case (ctrl_q)
      CtrlIn: begin
        if (in_acc) begin
          ctrl_d = CtrlExec;
        end
      end
      CtrlExec: begin
        ctrl_d       = CtrlIn;
        out_byte_d   = 8'd0;
        out_sv_d     = 1'b1;
        out_status_d = StRun;
        out_fin_d    = 1'b0;
        unique case (op_q)
          OpLoad: ;
          OpStart: begin
            retries_d   = cfg_retry_q;
            cks_d       = 8'd0;
            idx_d       = '0;
            phase_d     = PhSync;
            out_byte_d  = StartCode;
            out_valid_d = 1'b1;
          end
          default: begin
            if (phase_q == PhIdle) begin
              // drop: exchange outside a transfer
            end else if (op_q == OpTimeout) begin
              phase_d      = PhIdle;
              out_sv_d     = 1'b0;
              out_status_d = StTimeout;
              out_fin_d    = 1'b1;
              out_valid_d  = 1'b1;
            end else begin
              out_valid_d = 1'b1;
              unique case (phase_q)
                PhSync: begin
                  if (data_q != StartCode) begin
                    phase_d      = PhIdle;
                    out_sv_d     = 1'b0;
                    out_status_d = StConn;
                    out_fin_d    = 1'b1;
                  end else begin
                    phase_d    = PhRetry;
                    out_byte_d = cfg_retry_q;
                  end
                end
                PhRetry: begin
                  phase_d    = PhSizeLo;
                  out_byte_d = eff_size[7:0];
                end
                PhSizeLo: begin
                  phase_d    = PhSizeHi;
                  out_byte_d = {{(16-SizeW){1'b0}}, eff_size[SizeW-1:8]};
                end
                PhSizeHi: do_pass = 1'b1;
                PhData:   do_next = 1'b1;
                PhCheck: begin
                  if (data_q == cks_q) begin
                    phase_d      = PhIdle;
                    out_sv_d     = 1'b0;
                    out_status_d = StOk;
                    out_fin_d    = 1'b1;
                  end else begin
                    pass_retries = (retries_q != 8'd0) ? retries_q - 8'd1 : 8'd0;
                    retries_d    = pass_retries;
                    do_pass      = 1'b1;
                  end
                end
                default: out_valid_d = 1'b0;
              endcase
            end
          end
        endcase

        // Start a data pass, or give up when the retries are used up
        if (do_pass) begin
          if (pass_retries == 8'd0) begin
            phase_d      = PhIdle;
            out_sv_d     = 1'b0;
            out_status_d = StCrc;
            out_fin_d    = 1'b1;
          end else begin
            idx_use = '0;
            cks_use = 8'd0;
            cks_d   = 8'd0;
            idx_d   = '0;
            do_next = 1'b1;
          end
        end

        // Next data byte from memory, or the checksum once the block is out
        if (do_next) begin
          if (idx_use < eff_size) begin
            cks_d      = cks_use ^ mem_rdata;
            idx_d      = idx_use + SizeW'(1);
            phase_d    = PhData;
            out_byte_d = mem_rdata;
          end else begin
            phase_d    = PhCheck;
            out_byte_d = cks_use;
          end
        end

        if (out_valid_d) begin
          ctrl_d = CtrlOut;
        end
      end
      CtrlOut: begin
        if (m_axis_tready_i) begin
          out_valid_d = 1'b0;
          ctrl_d      = CtrlIn;
        end
      end
      default: ctrl_d = CtrlIn;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q       <= CtrlIn;
      phase_q      <= PhIdle;
      idx_q        <= '0;
      cks_q        <= 8'd0;
      retries_q    <= 8'd0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= 8'd0;
      out_sv_q     <= 1'b0;
      out_status_q <= StRun;
      out_fin_q    <= 1'b0;
    end else begin
      ctrl_q       <= ctrl_d;
      phase_q      <= phase_d;
      idx_q        <= idx_d;
      cks_q        <= cks_d;
      retries_q    <= retries_d;
      out_valid_q  <= out_valid_d;
      out_byte_q   <= out_byte_d;
      out_sv_q     <= out_sv_d;
      out_status_q <= out_status_d;
      out_fin_q    <= out_fin_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_status_q, out_sv_q, out_byte_q};
  assign m_axis_tlast_o  = out_fin_q;

`ifndef SYNTHESIS
  // An end item carries no byte to send
  a_end_item_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[8:0] == 9'd0)
    else $error("end item carries a send byte");

  // No new item is taken while a result waits
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while result pending");

  // An accepted item always moves to execute in the cycle after its accept
  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> ctrl_q == CtrlExec)
    else $error("accepted item skipped execute");

  // The data index never exceeds the memory depth
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= BlockMax)
    else $error("byte index beyond block memory");
`endif

endmodule
